// ===== hw/rtl/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the sorted value table
// Request and result formats, request and status codes, table sizing.
// ----------------------------------------------------------------------------
package svt_pkg;

  // Table sizing
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 64;
  localparam int POS_W    = 8;
  localparam int FILL_W   = 9;

  // Request codes
  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
  } svt_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill;
  } svt_res_t;

  // Outcome of the shared comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } svt_cmp_t;

endpackage

// ===== hw/rtl/svt_cmp.sv =====
// ----------------------------------------------------------------------------
// svt_cmp: shared signed magnitude comparator
// Compares a stored entry against the request key for every search step.
// ----------------------------------------------------------------------------
module svt_cmp (
  input  logic signed [svt_pkg::VAL_W-1:0] entry,
  input  logic signed [svt_pkg::VAL_W-1:0] key,
  output svt_pkg::svt_cmp_t                rel
);
  import svt_pkg::*;

  // Signed order: entry below key, or equal to it
  always_comb begin
    rel.lt = (entry < key);
    rel.eq = (entry == key);
  end

endmodule

// ===== hw/rtl/svt_core.sv =====
// ----------------------------------------------------------------------------
// svt_core: table memory and request sequencer
// Runs the binary search through one comparator, then moves entries one at
// a time, a read state and a write state each, to open or close a gap.
// ----------------------------------------------------------------------------
module svt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  svt_pkg::svt_req_t req,
  output logic              idle,
  output logic              done,
  input  logic              ack,
  output svt_pkg::svt_res_t result
);
  import svt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_ADR = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHU_RD   = 3'd3;
  localparam logic [2:0] S_SHU_WR   = 3'd4;
  localparam logic [2:0] S_SHD_RD   = 3'd5;
  localparam logic [2:0] S_SHD_WR   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]              state;
  logic [1:0]              op;
  logic signed [VAL_W-1:0] key;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hp;      // one past the upper search bound
  logic [IDX_W-1:0]        mid;
  logic [CNT_W-1:0]        ptr;
  logic [CNT_W-1:0]        count;
  logic [1:0]              status;
  logic                    found;

  // Table memory
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata;
  logic                    we;
  logic [IDX_W-1:0]        wa;
  logic signed [VAL_W-1:0] wd;
  logic [IDX_W-1:0]        ra;

  svt_cmp_t                rel;
  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid_calc;

  svt_cmp u_cmp (
    .entry (rdata),
    .key   (key),
    .rel   (rel)
  );

  // Midpoint: floor for exact search, upper bound for insert placement
  always_comb begin
    mid_sum = {1'b0, lo} + {1'b0, hp};
    if (op != REQ_INSERT) begin
      mid_sum = mid_sum - {{CNT_W{1'b0}}, 1'b1};
    end
    mid_calc = mid_sum[IDX_W:1];
  end

  // Memory port control
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    ra = '0;
    unique case (state)
      S_SRCH_ADR: ra = mid_calc;
      S_SHU_RD: begin
        if (ptr > lo) begin
          ra = IDX_W'(ptr - CNT_W'(1));
        end else begin
          we = 1'b1;
          wa = lo[IDX_W-1:0];
          wd = key;
        end
      end
      S_SHU_WR: begin
        we = 1'b1;
        wa = ptr[IDX_W-1:0];
      end
      S_SHD_RD: ra = ptr[IDX_W-1:0];
      S_SHD_WR: begin
        we = 1'b1;
        wa = IDX_W'(ptr - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op     <= req.req_type;
            key    <= req.value;
            lo     <= '0;
            hp     <= count;
            mid    <= '0;
            status <= ST_OK;
            found  <= 1'b0;
            unique case (req.req_type)
              REQ_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              REQ_INSERT: begin
                if (count >= CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  state <= S_SRCH_ADR;
                end
              end
              default: state <= S_SRCH_ADR;
            endcase
          end
        end
        S_SRCH_ADR: begin
          if (lo < hp) begin
            mid   <= mid_calc;
            state <= S_SRCH_CMP;
          end else if (op == REQ_INSERT) begin
            ptr   <= count;
            state <= S_SHU_RD;
          end else begin
            status <= ST_NOT_FOUND;
            state  <= S_DONE;
          end
        end
        S_SRCH_CMP: begin
          if (op == REQ_INSERT) begin
            if (rel.lt || rel.eq) begin
              lo <= CNT_W'(mid) + CNT_W'(1);
            end else begin
              hp <= CNT_W'(mid);
            end
            state <= S_SRCH_ADR;
          end else if (rel.eq) begin
            if (op == REQ_FIND) begin
              found <= 1'b1;
              state <= S_DONE;
            end else begin
              ptr   <= CNT_W'(mid) + CNT_W'(1);
              state <= S_SHD_RD;
            end
          end else begin
            if (rel.lt) begin
              lo <= CNT_W'(mid) + CNT_W'(1);
            end else begin
              hp <= CNT_W'(mid);
            end
            state <= S_SRCH_ADR;
          end
        end
        S_SHU_RD: begin
          if (ptr > lo) begin
            state <= S_SHU_WR;
          end else begin
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHU_WR: begin
          ptr   <= ptr - CNT_W'(1);
          state <= S_SHU_RD;
        end
        S_SHD_RD: begin
          if (ptr < count) begin
            state <= S_SHD_WR;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHD_WR: begin
          ptr   <= ptr + CNT_W'(1);
          state <= S_SHD_RD;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result view
  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.status   = status;
    result.found    = found;
    result.position = found ? POS_W'(mid) : '0;
    result.fill     = FILL_W'(count);
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_shift_up_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHU_RD || state == S_SHU_WR) |-> count < CNT_W'(CAPACITY))
    else $error("insert shift on a full table");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK && op == REQ_FIND))
    else $error("match flagged on a non-find or failing request");

  a_write_only_shift: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SHU_RD || state == S_SHU_WR || state == S_SHD_WR))
    else $error("memory write outside a shift");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (start && req.req_type == REQ_CLEAR) |=> count == '0)
    else $error("clear left entries");

endmodule

// ===== hw/rtl/sorted_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table_unit: ascending table of signed 64-bit values
// Find, insert, remove and clear requests, one result per request.
// ----------------------------------------------------------------------------
//  channel | signals                    | payload
//  --------+----------------------------+-----------------------------------
//  request | req_valid, req_ready, req  | req_type, value
//  result  | res_valid, res_ready, res  | status, found, position, fill
//
//  Find: each search step is an address state and a compare state, up to
//  log2(fill)+1 steps. Insert and remove add a read and a write state per
//  moved entry (single memory port pair); clear and a full insert skip search.
//  One request at a time; req_ready is high only while the sequencer is idle.
//  Reset empties the table at once; no memory sweep is needed.
//  A result waits in the output register; the next request is taken
//  meanwhile, and its result holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module sorted_value_table_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  svt_pkg::svt_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output svt_pkg::svt_res_t res
);
  import svt_pkg::*;

  logic     core_idle;
  logic     core_done;
  logic     core_ack;
  svt_res_t core_res;

  svt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (req_valid && req_ready),
    .req    (req),
    .idle   (core_idle),
    .done   (core_done),
    .ack    (core_ack),
    .result (core_res)
  );

  assign req_ready = core_idle;

  // Move a finished result into the output slot when it is free
  assign core_ack = core_done && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (core_ack) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_ack) begin
      res <= core_res;
    end
  end

endmodule
